// ===== hdl/phs_pkg.sv =====
// Package for the particle height-field step block.
// Holds the grid constants, register indexes, beat and config types and shared arithmetic.
// No dependencies.
`timescale 1ns / 1ps
package phs_pkg;

	localparam int GRID_SIZE = 64;
	localparam int CELL_W = $clog2(GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int GRID_W = $clog2(GRID_SIZE + 1);
	localparam int SCALE_W = 33 + GRID_W;
	localparam int FRAC_BITS = 24;
	localparam int MUL_W = 59;
	localparam int PIPE_STAGES = 7;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VSPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE = 3'd4;

	localparam logic [24:0] RST_TIME_STEP = 25'd16777;
	localparam logic [24:0] RST_LIFT_GAIN = 25'd5033165;
	localparam logic [24:0] RST_FALL_STEP = 25'd503316;
	localparam logic signed [31:0] RST_MIN_VSPEED = -32'sd20132659;
	localparam logic [24:0] RST_CLEARANCE = 25'd1677722;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic signed [39:0] S32_MAX_W = 40'sd2147483647;
	localparam logic signed [39:0] S32_MIN_W = -40'sd2147483648;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         cell_row;
		logic [5:0]         cell_col;
		logic signed [31:0] height_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_y;
	} phs_item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
	} phs_result_t;

	typedef struct packed {
		logic [24:0]        time_step;
		logic [24:0]        lift_gain;
		logic [24:0]        fall_step;
		logic signed [31:0] min_vertical_speed;
		logic [24:0]        ground_clearance;
	} phs_cfg_t;

	typedef struct packed {
		logic signed [31:0] h;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] vy;
	} phs_lookup_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > S32_MAX_W) begin
			return S32_MAX_W[31:0];
		end
		if (v < S32_MIN_W) begin
			return S32_MIN_W[31:0];
		end
		return v[31:0];
	endfunction

	// Grid cell of one coordinate: floor((p + 2) * GRID_SIZE / 4), clamped to the grid.
	function automatic logic [CELL_W-1:0] cell_of(input logic signed [31:0] p);
		logic signed [32:0] t;
		logic [SCALE_W-1:0] s;
		logic [SCALE_W-1:0] c;
		t = 33'(p) + 33'sd33554432;
		s = SCALE_W'(t[31:0]) * SCALE_W'(GRID_SIZE);
		c = s >> (FRAC_BITS + 2);
		if (t[32]) begin
			return '0;
		end
		if (c > SCALE_W'(GRID_SIZE - 1)) begin
			return CELL_W'(GRID_SIZE - 1);
		end
		return CELL_W'(c);
	endfunction

endpackage

// ===== hdl/particle_heightfield_step.sv =====
// Top level of the particle height-field step block: configuration registers and the pipeline.
// Depends on phs_pkg, phs_terrain and phs_dynamics.
`timescale 1ns / 1ps
// The block accepts one beat per clock cycle while its input stage is ready, either a terrain
// height load or a particle step, and raises result_valid for a step once it reaches the
// output register. Throughput is set by the single-port height memory, which each beat uses
// once as it moves from the first to the second stage. Stages hold their contents under
// back-pressure and empty stages keep accepting beats. Heights must be loaded before any
// particle reads them, and the user must write configuration only while no beat is in
// flight; the block itself does not enforce this.
module particle_heightfield_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [phs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  phs_pkg::phs_item_t                item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output phs_pkg::phs_result_t              result
);
	import phs_pkg::*;

	phs_cfg_t    cfg_q;
	logic        lk_valid;
	logic        lk_ready;
	phs_lookup_t lk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step          <= RST_TIME_STEP;
			cfg_q.lift_gain          <= RST_LIFT_GAIN;
			cfg_q.fall_step          <= RST_FALL_STEP;
			cfg_q.min_vertical_speed <= RST_MIN_VSPEED;
			cfg_q.ground_clearance   <= RST_CLEARANCE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TIME_STEP: begin
					cfg_q.time_step <= cfg_data[24:0];
				end
				REG_LIFT_GAIN: begin
					cfg_q.lift_gain <= cfg_data[24:0];
				end
				REG_FALL_STEP: begin
					cfg_q.fall_step <= cfg_data[24:0];
				end
				REG_MIN_VSPEED: begin
					cfg_q.min_vertical_speed <= cfg_data;
				end
				REG_CLEARANCE: begin
					cfg_q.ground_clearance <= cfg_data[24:0];
				end
				default: begin
				end
			endcase
		end
	end

	phs_terrain u_terrain (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.lk_valid   (lk_valid),
		.lk_ready   (lk_ready),
		.lk         (lk)
	);

	phs_dynamics u_dynamics (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.lk_valid     (lk_valid),
		.lk_ready     (lk_ready),
		.lk           (lk),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hdl/phs_terrain.sv =====
// Input stage and terrain lookup: input register, cell index, height memory write and read.
// Depends on phs_pkg.
`timescale 1ns / 1ps
module phs_terrain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  phs_pkg::phs_item_t  item,
	output logic                lk_valid,
	input  logic                lk_ready,
	output phs_pkg::phs_lookup_t lk
);
	import phs_pkg::*;

	logic              v_s1;
	logic              v_s2;
	phs_item_t         item_s1;
	phs_lookup_t       lk_s2;
	logic              rdy_s1;
	logic              rdy_s2;
	logic              mv_s1;
	logic              load_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       mem [0:DEPTH-1];

	assign rdy_s2 = !v_s2 || lk_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_ready = rdy_s1;
	assign mv_s1 = v_s1 && rdy_s2;

	assign load_ok = (int'(item_s1.cell_row) < GRID_SIZE) && (int'(item_s1.cell_col) < GRID_SIZE);
	assign wr_addr = ADDR_W'(int'(item_s1.cell_row) * GRID_SIZE + int'(item_s1.cell_col));
	assign rd_addr = ADDR_W'(int'(cell_of(item_s1.pos_x)) * GRID_SIZE
		+ int'(cell_of(item_s1.pos_z)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= item_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1 && (item_s1.cmd == CMD_STEP);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			item_s1 <= item;
		end
	end

	// Loads and lookups use the memory at the same stage, so program order holds.
	always_ff @(posedge clk) begin
		if (mv_s1 && (item_s1.cmd == CMD_LOAD) && load_ok) begin
			mem[wr_addr] <= item_s1.height_value;
		end
		if (mv_s1 && (item_s1.cmd == CMD_STEP)) begin
			lk_s2.h  <= mem[rd_addr];
			lk_s2.x  <= item_s1.pos_x;
			lk_s2.y  <= item_s1.pos_y;
			lk_s2.z  <= item_s1.pos_z;
			lk_s2.vy <= item_s1.vel_y;
		end
	end

	assign lk_valid = v_s2;
	assign lk = lk_s2;

endmodule

// ===== hdl/phs_dynamics.sv =====
// Particle dynamics pipeline: lift or fall, speed floor, integration and the output register.
// Depends on phs_pkg.
`timescale 1ns / 1ps
module phs_dynamics (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phs_pkg::phs_cfg_t    cfg,
	input  logic                 lk_valid,
	output logic                 lk_ready,
	input  phs_pkg::phs_lookup_t lk,
	output logic                 result_valid,
	input  logic                 result_ready,
	output phs_pkg::phs_result_t result
);
	import phs_pkg::*;

	logic v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	logic signed [25:0] ts;
	logic signed [31:0] target;
	logic signed [32:0] gap;
	logic signed [31:0] vx;
	logic signed [31:0] vy_fall;
	logic signed [34:0] lift_q;
	logic signed [34:0] px_q;
	logic signed [34:0] pz_q;
	logic signed [34:0] py_q;
	logic signed [31:0] vy_up;
	logic signed [31:0] vy_sel;

	logic signed [32:0] gap_s3;
	logic               lift_s3;
	logic signed [31:0] vx_s3, vy_fall_s3, x_s3, y_s3, z_s3, vy_s3;

	logic signed [MUL_W-1:0] prod_lift_s4, prod_x_s4, prod_z_s4;
	logic               lift_s4;
	logic signed [31:0] vx_s4, vy_fall_s4, x_s4, y_s4, z_s4, vy_s4;

	logic signed [31:0] vy_s5, nx_s5, nz_s5, y_s5, vx_s5, vz_s5;

	logic signed [MUL_W-1:0] prod_y_s6;
	logic signed [31:0] vy_s6, nx_s6, nz_s6, y_s6, vx_s6, vz_s6;

	phs_result_t        result_s7;

	assign rdy_s7 = !v_s7 || result_ready;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign lk_ready = rdy_s3;

	assign ts = $signed({1'b0, cfg.time_step});

	assign target = sat32(40'(lk.h) + 40'($signed({1'b0, cfg.ground_clearance})));
	assign gap = 33'(target) - 33'(lk.y);
	assign vx = sat32(-40'(lk.z));
	assign vy_fall = sat32(40'(lk.vy) - 40'($signed({1'b0, cfg.fall_step})));

	assign lift_q = $signed(prod_lift_s4[MUL_W-1:FRAC_BITS]);
	assign px_q = $signed(prod_x_s4[MUL_W-1:FRAC_BITS]);
	assign pz_q = $signed(prod_z_s4[MUL_W-1:FRAC_BITS]);
	assign vy_up = sat32(40'(vy_s4) + 40'(sat32(40'(lift_q))));
	assign vy_sel = lift_s4 ? vy_up : vy_fall_s4;

	assign py_q = $signed(prod_y_s6[MUL_W-1:FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= lk_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
			if (rdy_s7) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && lk_valid) begin
			gap_s3     <= gap;
			lift_s3    <= target > lk.y;
			vx_s3      <= vx;
			vy_fall_s3 <= vy_fall;
			x_s3       <= lk.x;
			y_s3       <= lk.y;
			z_s3       <= lk.z;
			vy_s3      <= lk.vy;
		end
		if (rdy_s4 && v_s3) begin
			prod_lift_s4 <= MUL_W'(gap_s3) * MUL_W'($signed({1'b0, cfg.lift_gain}));
			prod_x_s4    <= MUL_W'(vx_s3) * MUL_W'(ts);
			prod_z_s4    <= MUL_W'(x_s3) * MUL_W'(ts);
			lift_s4      <= lift_s3;
			vx_s4        <= vx_s3;
			vy_fall_s4   <= vy_fall_s3;
			x_s4         <= x_s3;
			y_s4         <= y_s3;
			z_s4         <= z_s3;
			vy_s4        <= vy_s3;
		end
		if (rdy_s5 && v_s4) begin
			vy_s5 <= (vy_sel < cfg.min_vertical_speed) ? cfg.min_vertical_speed : vy_sel;
			nx_s5 <= sat32(40'(x_s4) + 40'(px_q));
			nz_s5 <= sat32(40'(z_s4) + 40'(pz_q));
			y_s5  <= y_s4;
			vx_s5 <= vx_s4;
			vz_s5 <= x_s4;
		end
		if (rdy_s6 && v_s5) begin
			prod_y_s6 <= MUL_W'(vy_s5) * MUL_W'(ts);
			vy_s6     <= vy_s5;
			nx_s6     <= nx_s5;
			nz_s6     <= nz_s5;
			y_s6      <= y_s5;
			vx_s6     <= vx_s5;
			vz_s6     <= vz_s5;
		end
		if (rdy_s7 && v_s6) begin
			result_s7.new_pos_x <= nx_s6;
			result_s7.new_pos_y <= sat32(40'(y_s6) + 40'(py_q));
			result_s7.new_pos_z <= nz_s6;
			result_s7.new_vel_x <= vx_s6;
			result_s7.new_vel_y <= vy_s6;
			result_s7.new_vel_z <= vz_s6;
		end
	end

	assign result_valid = v_s7;
	assign result = result_s7;

endmodule

// ===== hdl/phs_checker.sv =====
// Port-level checker for the particle height-field step block and its bind statement.
// Depends on phs_pkg and particle_heightfield_step.
`timescale 1ns / 1ps
module phs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_write,
	input logic [phs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data,
	input logic                          item_valid,
	input logic                          item_ready,
	input phs_pkg::phs_item_t            item,
	input logic                          result_valid,
	input logic                          result_ready,
	input phs_pkg::phs_result_t          result
);
	import phs_pkg::*;

	logic [3:0]         count_q;
	logic signed [31:0] min_q;
	logic               step_in;
	logic               beat_out;

	assign step_in = item_valid && item_ready && (item.cmd == CMD_STEP);
	assign beat_out = result_valid && result_ready;

	// Steps in flight: each accepted step must leave exactly one result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= RST_MIN_VSPEED;
		end else begin
			count_q <= count_q + 4'(step_in) - 4'(beat_out);
			if (cfg_write && (cfg_index == REG_MIN_VSPEED)) begin
				min_q <= cfg_data;
			end
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count_q != 4'd0)
		else $error("result beat without an outstanding step");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(PIPE_STAGES))
		else $error("more steps in flight than pipeline stages");

	a_vspeed_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $signed(result.new_vel_y) >= min_q)
		else $error("vertical speed below its floor");

endmodule

bind particle_heightfield_step phs_checker u_phs_checker (.*);

// ===== test/particle_heightfield_step_test.sv =====
// Self-checking testbench for particle_heightfield_step: random and directed height loads
// and particle steps against a built-in fixed-point predictor, under several register settings.
// Depends on phs_pkg and the particle_heightfield_step RTL.
`timescale 1ns / 1ps
module particle_heightfield_step_test;
	import phs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL = 160;
	localparam int SETTLE_CYCLES = PIPE_STAGES + 6;
	localparam int IDLE_PERCENT = 21;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_CLEARANCE + 3'd1;
	localparam longint Q_ONE = longint'(1) << FRAC_BITS;
	localparam longint S32_TOP = 64'sd2147483647;
	localparam longint S32_BOTTOM = -64'sd2147483648;
	localparam longint REG25_TOP = (longint'(1) << 25) - 1;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic item_valid;
	logic item_ready;
	phs_item_t item;
	logic result_valid;
	logic result_ready;
	phs_result_t result;

	logic signed [31:0] heights_mirror [DEPTH];
	bit height_loaded [DEPTH];
	longint step_q, gain_q, fall_q, vmin_q, clear_q;

	phs_result_t results_due [$];
	phs_result_t due_result;
	int mismatches;
	int results_checked;
	int loads_sent;
	int steps_sent;
	int settings_used;
	int cycle_count;
	bit steady_send;
	bit steady_recv;
	bit stall_request;
	int stall_left;

	particle_heightfield_step u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > S32_TOP) begin
			return S32_TOP;
		end
		if (v < S32_BOTTOM) begin
			return S32_BOTTOM;
		end
		return v;
	endfunction

	function automatic int grid_cell(input longint p);
		longint scaled;
		scaled = (p + 2 * Q_ONE) * GRID_SIZE;
		if (scaled < 0) begin
			return 0;
		end
		scaled = scaled >>> (FRAC_BITS + 2);
		return (scaled > GRID_SIZE - 1) ? GRID_SIZE - 1 : int'(scaled);
	endfunction

	function automatic int cell_address(input phs_item_t it);
		return grid_cell(longint'(it.pos_x)) * GRID_SIZE + grid_cell(longint'(it.pos_z));
	endfunction

	// Products are exact and shifted with floor rounding; every sum saturates.
	function automatic phs_result_t predict_step(input phs_item_t it);
		longint x, y, z, vy, vx, vz, h, target;
		phs_result_t r;
		x = longint'(it.pos_x);
		y = longint'(it.pos_y);
		z = longint'(it.pos_z);
		vy = longint'(it.vel_y);
		h = longint'(heights_mirror[cell_address(it)]);
		vx = clamp32(-z);
		vz = x;
		target = clamp32(h + clear_q);
		if (target > y) begin
			vy = clamp32(vy + clamp32(((target - y) * gain_q) >>> FRAC_BITS));
		end else begin
			vy = clamp32(vy - fall_q);
		end
		if (vy < vmin_q) begin
			vy = vmin_q;
		end
		r.new_pos_x = 32'(clamp32(x + ((vx * step_q) >>> FRAC_BITS)));
		r.new_pos_y = 32'(clamp32(y + ((vy * step_q) >>> FRAC_BITS)));
		r.new_pos_z = 32'(clamp32(z + ((vz * step_q) >>> FRAC_BITS)));
		r.new_vel_x = 32'(vx);
		r.new_vel_y = 32'(vy);
		r.new_vel_z = 32'(vz);
		return r;
	endfunction

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 9))
			0: begin
				return 32'sh7FFFFFFF;
			end
			1: begin
				return 32'sh80000000;
			end
			2, 3: begin
				return $urandom;
			end
			default: begin
				return 32'(longint'($urandom_range(0, 32'd6 << FRAC_BITS)) - 3 * Q_ONE);
			end
		endcase
	endfunction

	function automatic phs_item_t load_item(input int row, input int col, input longint h);
		phs_item_t it;
		it.cmd = CMD_LOAD;
		it.cell_row = 6'(row);
		it.cell_col = 6'(col);
		it.height_value = 32'(h);
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		it.vel_y = $urandom;
		return it;
	endfunction

	function automatic phs_item_t step_item(input longint x, input longint y, input longint z,
			input longint vy);
		phs_item_t it;
		it.cmd = CMD_STEP;
		it.cell_row = 6'($urandom);
		it.cell_col = 6'($urandom);
		it.height_value = $urandom;
		it.pos_x = 32'(x);
		it.pos_y = 32'(y);
		it.pos_z = 32'(z);
		it.vel_y = 32'(vy);
		return it;
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			note_failure($sformatf("%s expected %0d (%h) got %0d (%h)", name, want, want, got,
				got));
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (results_due.size() == 0) begin
				note_failure($sformatf("result beat with no step waiting: %h", result));
			end else begin
				due_result = results_due.pop_front();
				check_field("new_pos_x", due_result.new_pos_x, result.new_pos_x);
				check_field("new_pos_y", due_result.new_pos_y, result.new_pos_y);
				check_field("new_pos_z", due_result.new_pos_z, result.new_pos_z);
				check_field("new_vel_x", due_result.new_vel_x, result.new_vel_x);
				check_field("new_vel_y", due_result.new_vel_y, result.new_vel_y);
				check_field("new_vel_z", due_result.new_vel_z, result.new_vel_z);
				results_checked++;
			end
		end
	end

	// Output side: random back-pressure, quiet stretches, and long hold-offs on request.
	initial begin
		result_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_left = LONG_STALL;
				stall_request = 1'b0;
			end
			if (!arst_n) begin
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady_recv || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_item(input phs_item_t it);
		@(negedge clk);
		while (!steady_send && $urandom_range(0, 99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		if (it.cmd == CMD_LOAD) begin
			heights_mirror[{it.cell_row, it.cell_col}] = it.height_value;
			height_loaded[{it.cell_row, it.cell_col}] = 1'b1;
			loads_sent++;
		end else begin
			results_due = {results_due, predict_step(it)};
			steps_sent++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_TIME_STEP: begin
				step_q = longint'(data[24:0]);
			end
			REG_LIFT_GAIN: begin
				gain_q = longint'(data[24:0]);
			end
			REG_FALL_STEP: begin
				fall_q = longint'(data[24:0]);
			end
			REG_MIN_VSPEED: begin
				vmin_q = longint'(signed'(data));
			end
			REG_CLEARANCE: begin
				clear_q = longint'(data[24:0]);
			end
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] ts, input logic [31:0] gain,
			input logic [31:0] fall, input logic [31:0] vmin, input logic [31:0] clear);
		write_register(REG_TIME_STEP, ts);
		write_register(REG_LIFT_GAIN, gain);
		write_register(REG_FALL_STEP, fall);
		write_register(REG_MIN_VSPEED, vmin);
		write_register(REG_CLEARANCE, clear);
		settings_used++;
	endtask

	// Mostly steps over loaded cells, with y placed near terrain plus clearance so that
	// both the lift and the fall branch and their boundary are hit.
	task automatic run_random_traffic(input int count);
		phs_item_t it;
		int addr;
		longint delta;
		repeat (count) begin
			if ($urandom_range(0, 99) < 25) begin
				send_item(load_item($urandom_range(0, GRID_SIZE - 1),
					$urandom_range(0, GRID_SIZE - 1), longint'(rand_q())));
			end else begin
				it = step_item(longint'(rand_q()), longint'(rand_q()), longint'(rand_q()),
					longint'(rand_q()));
				addr = cell_address(it);
				if (!height_loaded[addr]) begin
					send_item(load_item(addr / GRID_SIZE, addr % GRID_SIZE,
						longint'(rand_q())));
				end
				if ($urandom_range(0, 3) != 0) begin
					delta = $urandom_range(0, 1) ? longint'($urandom_range(0, 8)) - 4 :
						longint'($urandom_range(0, 32'd2 << FRAC_BITS)) - Q_ONE;
					it.pos_y = 32'(clamp32(clamp32(longint'(heights_mirror[addr]) + clear_q)
						+ delta));
				end
				send_item(it);
			end
		end
	endtask

	task automatic test_directed_cases();
		send_item(load_item(0, 0, 0));
		send_item(load_item(GRID_SIZE - 1, GRID_SIZE - 1, S32_TOP));
		send_item(load_item(0, GRID_SIZE - 1, S32_BOTTOM));
		send_item(load_item(GRID_SIZE - 1, 0, Q_ONE));
		send_item(load_item(GRID_SIZE / 2, GRID_SIZE / 2, -Q_ONE));
		send_item(load_item(GRID_SIZE / 2 - 1, GRID_SIZE / 2, Q_ONE));
		// Exactly on terrain plus clearance, so the fall step applies.
		send_item(step_item(-2 * Q_ONE, clear_q, -2 * Q_ONE, 0));
		send_item(step_item(-2 * Q_ONE - 1, S32_BOTTOM, 2 * Q_ONE - 1, S32_BOTTOM));
		send_item(step_item(S32_TOP, S32_TOP, S32_TOP, S32_BOTTOM));
		send_item(step_item(S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_TOP));
		send_item(step_item(2 * Q_ONE, 0, -2 * Q_ONE, 0));
		send_item(step_item(0, 0, 0, 0));
		send_item(step_item(0, clear_q - Q_ONE - 1, 0, 0));
		// A step that reads the cell written by the beat just before it.
		send_item(load_item(GRID_SIZE / 2, GRID_SIZE / 2, 3 * Q_ONE));
		send_item(step_item(0, 0, 0, Q_ONE));
		send_item(step_item(-1, S32_TOP, 0, S32_TOP));
		wait_drained();
	endtask

	task automatic test_default_settings();
		run_random_traffic(150);
		wait_drained();
	endtask

	task automatic test_unlisted_index();
		for (int i = int'(REG_FIRST_UNUSED); i < 2 ** CFG_IDX_W; i++) begin
			write_register(CFG_IDX_W'(i), $urandom);
		end
		run_random_traffic(12);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		apply_settings(32'(REG25_TOP), 32'(REG25_TOP), 32'(REG25_TOP), 32'h80000000,
			32'(REG25_TOP));
		run_random_traffic(80);
		wait_drained();
		apply_settings(0, 0, 0, 0, 0);
		run_random_traffic(70);
		wait_drained();
		apply_settings(32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE), 32'(-Q_ONE), 32'(Q_ONE));
		run_random_traffic(70);
		wait_drained();
	endtask

	task automatic test_random_settings();
		logic [31:0] vmin;
		repeat (3) begin
			vmin = $urandom_range(0, 3) == 0 ? 32'h80000000 :
				32'(-longint'($urandom_range(0, 32'h7FFFFFFF)));
			// Bits above the register width are written too and must be dropped.
			apply_settings({7'($urandom_range(0, 127)), 25'($urandom)},
				{7'($urandom_range(0, 127)), 25'($urandom)},
				{7'($urandom_range(0, 127)), 25'($urandom)}, vmin,
				{7'($urandom_range(0, 127)), 25'($urandom)});
			run_random_traffic(50);
			wait_drained();
		end
	endtask

	task automatic test_no_idle_stretch();
		steady_send = 1'b1;
		steady_recv = 1'b1;
		run_random_traffic(90);
		steady_send = 1'b0;
		steady_recv = 1'b0;
		wait_drained();
	endtask

	// The output holds off while beats keep coming, so the pipeline fills and stalls its input.
	task automatic test_output_stall();
		apply_settings(32'(RST_TIME_STEP), 32'(RST_LIFT_GAIN), 32'(RST_FALL_STEP),
			RST_MIN_VSPEED, 32'(RST_CLEARANCE));
		steady_send = 1'b1;
		stall_request = 1'b1;
		run_random_traffic(50);
		steady_send = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		stall_request = 1'b0;
		mismatches = 0;
		results_checked = 0;
		loads_sent = 0;
		steps_sent = 0;
		settings_used = 1;
		step_q = longint'(RST_TIME_STEP);
		gain_q = longint'(RST_LIFT_GAIN);
		fall_q = longint'(RST_FALL_STEP);
		vmin_q = longint'(RST_MIN_VSPEED);
		clear_q = longint'(RST_CLEARANCE);
		foreach (heights_mirror[i]) begin
			heights_mirror[i] = '0;
			height_loaded[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_default_settings();
		test_unlisted_index();
		test_register_extremes();
		test_random_settings();
		test_no_idle_stretch();
		test_output_stall();

		wait_drained();
		$display("Sent %0d height loads and %0d particle steps under %0d register settings,",
			loads_sent, steps_sent, settings_used);
		$display("with random idling, a long output hold-off and %0d results checked.",
			results_checked);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
